@@ sv/sspc_pkg.sv @@
package sspc_pkg;

	localparam int unsigned TimeW   = 32;
	localparam int unsigned StepW   = 22;
	localparam int unsigned TpuW    = 10;
	localparam int unsigned CfgW    = 22;
	localparam int unsigned CfgIdxW = 2;

	localparam logic [StepW-1:0] StepTimeRst = StepW'(125000);
	localparam logic [TpuW-1:0]  TpuRst      = TpuW'(200);
	localparam logic [TimeW-1:0] StepTicksRst = TimeW'(125000 * 200);
	localparam logic [TimeW-1:0] GateTicksRst = TimeW'((125000 / 2) * 200);

	typedef enum logic [2:0] {
		FUNC_RESTART = 3'd0,
		FUNC_START   = 3'd1,
		FUNC_SYNC    = 3'd2,
		FUNC_BG_POLL = 3'd3,
		FUNC_FG_POLL = 3'd4
	} func_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_SYNC_SOURCE  = 2'd0,
		REG_STEP_TIME    = 2'd1,
		REG_TICKS_PER_US = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [2:0]       func;
		logic [TimeW-1:0] time_stamp;
		logic             gate_on;
		logic             step_slides;
	} in_item_t;

	typedef struct packed {
		logic go_first_step;
		logic advance_step;
		logic activate_step;
		logic gate_off;
	} out_item_t;

	typedef struct packed {
		logic             pulse_mode;
		logic [TimeW-1:0] step_ticks;
		logic [TimeW-1:0] gate_ticks;
	} cfg_t;

endpackage

@@ sv/sspc_cfg.sv @@
module sspc_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sspc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [sspc_pkg::CfgW-1:0]     cfg_wdata,
	output sspc_pkg::cfg_t                cfg
);
	import sspc_pkg::*;

	logic             src_q, src_d;
	logic [StepW-1:0] step_time_q, step_time_d;
	logic [TpuW-1:0]  tpu_q, tpu_d;
	logic [TimeW-1:0] step_ticks_q, gate_ticks_q;
	logic [TimeW-1:0] step_prod, gate_prod;

	always_comb begin
		src_d       = src_q;
		step_time_d = step_time_q;
		tpu_d       = tpu_q;
		if (cfg_we) begin
			case (cfg_index)
				REG_SYNC_SOURCE:  src_d       = cfg_wdata[0];
				REG_STEP_TIME:    step_time_d = cfg_wdata[StepW-1:0];
				REG_TICKS_PER_US: tpu_d       = cfg_wdata[TpuW-1:0];
				default: ;
			endcase
		end
	end

	// products never exceed 32 bits at these field widths
	assign step_prod = TimeW'(step_time_d) * TimeW'(tpu_d);
	assign gate_prod = TimeW'(step_time_d >> 1) * TimeW'(tpu_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q        <= 1'b0;
			step_time_q  <= StepTimeRst;
			tpu_q        <= TpuRst;
			step_ticks_q <= StepTicksRst;
			gate_ticks_q <= GateTicksRst;
		end else if (cfg_we) begin
			src_q        <= src_d;
			step_time_q  <= step_time_d;
			tpu_q        <= tpu_d;
			step_ticks_q <= step_prod;
			gate_ticks_q <= gate_prod;
		end
	end

	assign cfg.pulse_mode = src_q;
	assign cfg.step_ticks = step_ticks_q;
	assign cfg.gate_ticks = gate_ticks_q;

endmodule

@@ sv/sspc_core.sv @@
module sspc_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  sspc_pkg::in_item_t   item,
	input  sspc_pkg::cfg_t       cfg,
	output sspc_pkg::out_item_t  result
);
	import sspc_pkg::*;

	logic [TimeW-1:0] step_start_q, step_start_d;
	logic [TimeW-1:0] last_sync_q, last_sync_d;
	logic [TimeW-1:0] period_q, period_d;
	logic sync_pend_q, sync_pend_d;
	logic half_done_q, half_done_d;
	logic pulse_pend_q, pulse_pend_d;
	logic first_seen_q, first_seen_d;
	logic [TimeW-1:0] elapsed, since_sync;

	assign elapsed = item.time_stamp - step_start_q;

	always_comb begin
		step_start_d = step_start_q;
		last_sync_d  = last_sync_q;
		period_d     = period_q;
		sync_pend_d  = sync_pend_q;
		half_done_d  = half_done_q;
		pulse_pend_d = pulse_pend_q;
		first_seen_d = first_seen_q;
		since_sync   = '0;
		result       = '0;
		case (item.func)
			FUNC_RESTART: begin
				result.go_first_step = 1'b1;
				result.activate_step = 1'b1;
				sync_pend_d          = 1'b0;
				period_d             = '0;
				half_done_d          = 1'b0;
			end
			FUNC_START: begin
				step_start_d         = item.time_stamp;
				result.go_first_step = 1'b1;
				result.activate_step = !cfg.pulse_mode;
				sync_pend_d          = 1'b0;
				period_d             = '0;
				first_seen_d         = 1'b0;
				pulse_pend_d         = 1'b0;
			end
			FUNC_SYNC: begin
				sync_pend_d = 1'b1;
			end
			FUNC_BG_POLL: begin
				if (cfg.pulse_mode) begin
					if (sync_pend_q) begin
						sync_pend_d  = 1'b0;
						period_d     = item.time_stamp - last_sync_q;
						last_sync_d  = item.time_stamp;
						half_done_d  = 1'b0;
						pulse_pend_d = 1'b1;
					end
					since_sync = item.time_stamp - last_sync_d;
					if (!half_done_d && since_sync >= (period_d >> 1)) begin
						half_done_d  = 1'b1;
						pulse_pend_d = 1'b1;
					end
				end
			end
			FUNC_FG_POLL: begin
				result.gate_off = item.gate_on && !item.step_slides &&
					(elapsed >= cfg.gate_ticks);
				if (!cfg.pulse_mode) begin
					if (elapsed >= cfg.step_ticks) begin
						step_start_d         = item.time_stamp;
						result.advance_step  = 1'b1;
						result.activate_step = 1'b1;
					end
				end else if (pulse_pend_q) begin
					pulse_pend_d         = 1'b0;
					step_start_d         = item.time_stamp;
					first_seen_d         = 1'b1;
					result.advance_step  = first_seen_q;
					result.activate_step = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_start_q <= '0;
			last_sync_q  <= '0;
			period_q     <= '0;
			sync_pend_q  <= 1'b0;
			half_done_q  <= 1'b0;
			pulse_pend_q <= 1'b0;
			first_seen_q <= 1'b0;
		end else if (fire) begin
			step_start_q <= step_start_d;
			last_sync_q  <= last_sync_d;
			period_q     <= period_d;
			sync_pend_q  <= sync_pend_d;
			half_done_q  <= half_done_d;
			pulse_pend_q <= pulse_pend_d;
			first_seen_q <= first_seen_d;
		end
	end

endmodule

@@ sv/step_sequencer_play_clock.sv @@
// Pipeline: an input beat is taken into the input register; its result beat is
// then loaded into the result register, which holds it until it is taken.
// Throughput: one beat per cycle unless out_ready stalls; timing state updates in one pass.
// Reset: arst_n clears all timing state and both stage valid flags, and loads
// the default configuration (internal timer, 125000 us step, 200 ticks/us).
module step_sequencer_play_clock (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  sspc_pkg::in_item_t            in_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output sspc_pkg::out_item_t           out_item,
	input  logic                          cfg_we,
	input  logic [sspc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [sspc_pkg::CfgW-1:0]     cfg_wdata
);
	import sspc_pkg::*;

	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t out_item_q;
	logic      out_valid_q;
	out_item_t result;
	cfg_t      cfg;
	logic      fire;

	assign fire     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire;

	sspc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	sspc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_item_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule
